>>> src/assert_macros.svh
// assertion macros for the semaphore bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> src/csb_pkg.sv
`timescale 1ns / 1ps
package csb_pkg;
   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_TAKE   = 2'd2,
      CMD_GIVE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_PARAM  = 3'd1,
      ST_NOSLOT = 3'd2,
      ST_BLOCK  = 3'd3,
      ST_QUEUED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_WALK,
      S_DRAIN,
      S_CREATE
   } state_type;

   localparam int unsigned MAX_RESULTS = 16;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  sem_index;
      logic [31:0] create_count;
      logic [3:0]  task_id;
      logic [7:0]  task_priority;
      logic        may_wait;
      logic        sched_allowed;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] new_sem_index;
      logic       woken_valid;
      logic [3:0] woken_task;
      logic       woken_result;
      logic       switch_hint;
      logic       last;
   } rsp_type;
endpackage

>>> src/counting_semaphore_bank.sv
// create: one slot probed per cycle until a free one is found,
// take: one queue entry walked per cycle,
// delete wakes each waiter in turn, give and the other commands answer from the decide state.
// one word at a time: busy stays high until the last result is strobed,
// results go out on fixed cycles, the receiver cannot stall them.
// reset: synchronous active high, all slots free, all queues empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module counting_semaphore_bank #(
   parameter int SEM_SLOTS  = 16,
   parameter int TASK_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  csb_pkg::req_type  req_word,
   output logic              rsp_strobe,
   output csb_pkg::rsp_type  rsp_word
);
   import csb_pkg::*;

   localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
   localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(MAX_RESULTS + 1);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [SEM_SLOTS-1:0]    used_ff, used_in;
   logic [31:0]             count_ff [SEM_SLOTS];
   logic [TW-1:0]           head_ff [SEM_SLOTS];
   logic [SEM_SLOTS-1:0]    hok_ff, hok_in;
   logic [TW-1:0]           next_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]   nok_ff, nok_in;
   logic [7:0]              prio_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]   wait_ff, wait_in;
   logic [TW-1:0]           cur_ff, cur_in, prev_ff, prev_in;
   logic                    cok_ff, cok_in, hprev_ff, hprev_in;
   logic [SW:0]             scan_ff, scan_in;
   logic [CW-1:0]           nres_ff, nres_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   // single write port per table
   logic                    cnt_we;
   logic [31:0]             cnt_wd;
   logic                    head_we;
   logic [TW-1:0]           head_wd;
   logic                    next_we;
   logic [TW-1:0]           next_wa, next_wd;
   logic                    prio_we;

   logic [SW-1:0]           s_idx;
   logic [TW-1:0]           t_idx;
   logic                    s_ok, t_ok;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   assign s_idx = SW'(req_ff.sem_index);
   assign t_idx = TW'(req_ff.task_id);
   assign s_ok  = (32'(req_ff.sem_index) < 32'(SEM_SLOTS)) && used_ff[s_idx];
   assign t_ok  = (32'(req_ff.task_id) < 32'(TASK_SLOTS)) && !wait_ff[t_idx];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      used_in       = used_ff;
      hok_in        = hok_ff;
      nok_in        = nok_ff;
      wait_in       = wait_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cok_in        = cok_ff;
      hprev_in      = hprev_ff;
      scan_in       = scan_ff;
      nres_in       = nres_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      cnt_we        = 1'b0;
      cnt_wd        = count_ff[s_idx];
      head_we       = 1'b0;
      head_wd       = cur_ff;
      next_we       = 1'b0;
      next_wa       = t_idx;
      next_wd       = cur_ff;
      prio_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               scan_in  = '0;
               nres_in  = '0;
               state_in = (cmd_type'(req_word.command) == CMD_CREATE) ? S_CREATE : S_DECIDE;
            end
         end
         S_CREATE: begin
            rsp_in.last = 1'b1;
            if (32'(scan_ff) >= 32'(SEM_SLOTS)) begin
               rsp_in.status = ST_NOSLOT;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (!used_ff[scan_ff[SW-1:0]]) begin
               used_in[scan_ff[SW-1:0]] = 1'b1;
               hok_in[scan_ff[SW-1:0]]  = 1'b0;
               rsp_in.status        = ST_OK;
               rsp_in.new_sem_index = 4'(scan_ff);
               rsp_strobe_in        = 1'b1;
               state_in             = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            rsp_in.last = 1'b1;
            if (!s_ok) begin
               rsp_in.status = ST_PARAM;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               case (cmd_type'(req_ff.command))
                  CMD_DELETE: begin
                     state_in = S_DRAIN;
                  end
                  CMD_TAKE: begin
                     state_in = S_IDLE;
                     rsp_strobe_in = 1'b1;
                     if (count_ff[s_idx] != 32'd0) begin
                        cnt_we        = 1'b1;
                        cnt_wd        = count_ff[s_idx] - 32'd1;
                        rsp_in.status = ST_OK;
                     end else if (!req_ff.may_wait) begin
                        rsp_in.status = ST_BLOCK;
                     end else if (!t_ok) begin
                        rsp_in.status = ST_PARAM;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        cur_in   = head_ff[s_idx];
                        cok_in   = hok_ff[s_idx];
                        hprev_in = 1'b0;
                        scan_in  = '0;
                        next_we  = 1'b1;
                        next_wd  = head_ff[s_idx];
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_strobe_in      = 1'b1;
                     state_in           = S_IDLE;
                     rsp_in.status      = ST_OK;
                     rsp_in.switch_hint = req_ff.sched_allowed;
                     if (hok_ff[s_idx]) begin
                        hok_in[s_idx]              = nok_ff[head_ff[s_idx]];
                        head_we                    = 1'b1;
                        head_wd                    = next_ff[head_ff[s_idx]];
                        nok_in[head_ff[s_idx]]     = 1'b0;
                        wait_in[head_ff[s_idx]]    = 1'b0;
                        rsp_in.woken_valid         = 1'b1;
                        rsp_in.woken_task          = 4'(head_ff[s_idx]);
                     end else if (count_ff[s_idx] != 32'hFFFF_FFFF) begin
                        cnt_we = 1'b1;
                        cnt_wd = count_ff[s_idx] + 32'd1;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            if (cok_ff && 32'(scan_ff) < 32'(TASK_SLOTS) &&
                prio_ff[cur_ff] >= req_ff.task_priority) begin
               prev_in  = cur_ff;
               hprev_in = 1'b1;
               cok_in   = nok_ff[cur_ff];
               cur_in   = next_ff[cur_ff];
               scan_in  = scan_ff + 1'b1;
               // new task link follows the walk
               next_we  = 1'b1;
               next_wd  = next_ff[cur_ff];
            end else begin
               prio_we        = 1'b1;
               nok_in[t_idx]  = cok_ff;
               wait_in[t_idx] = 1'b1;
               if (hprev_ff) begin
                  next_we         = 1'b1;
                  next_wa         = prev_ff;
                  next_wd         = t_idx;
                  nok_in[prev_ff] = 1'b1;
               end else begin
                  head_we       = 1'b1;
                  head_wd       = t_idx;
                  hok_in[s_idx] = 1'b1;
               end
               rsp_in.status = ST_QUEUED;
               rsp_in.last   = 1'b1;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (hok_ff[s_idx]) begin
               hok_in[s_idx]           = nok_ff[head_ff[s_idx]];
               head_we                 = 1'b1;
               head_wd                 = next_ff[head_ff[s_idx]];
               nok_in[head_ff[s_idx]]  = 1'b0;
               wait_in[head_ff[s_idx]] = 1'b0;
               if (32'(nres_ff) < 32'(MAX_RESULTS)) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.woken_valid  = 1'b1;
                  rsp_in.woken_task   = 4'(head_ff[s_idx]);
                  rsp_in.woken_result = 1'b1;
                  rsp_in.last         = !nok_ff[head_ff[s_idx]];
                  nres_in             = nres_ff + 1'b1;
               end else if (!nok_ff[head_ff[s_idx]]) begin
                  used_in[s_idx] = 1'b0;
                  state_in       = S_IDLE;
               end
               if (!nok_ff[head_ff[s_idx]]) begin
                  used_in[s_idx] = 1'b0;
                  state_in       = S_IDLE;
               end
            end else begin
               rsp_strobe_in  = 1'b1;
               rsp_in.last    = 1'b1;
               used_in[s_idx] = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         hok_ff        <= '0;
         nok_ff        <= '0;
         wait_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         hok_ff        <= hok_in;
         nok_ff        <= nok_in;
         wait_ff       <= wait_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      cok_ff   <= cok_in;
      hprev_ff <= hprev_in;
      scan_ff  <= scan_in;
      nres_ff  <= nres_in;
      rsp_ff   <= rsp_in;
      if (state_ff == S_CREATE && rsp_strobe_in && rsp_in.status == ST_OK)
         count_ff[scan_ff[SW-1:0]] <= req_ff.create_count;
      else if (cnt_we)
         count_ff[s_idx] <= cnt_wd;
      if (head_we)
         head_ff[s_idx] <= head_wd;
      if (next_we)
         next_ff[next_wa] <= next_wd;
      if (prio_we)
         prio_ff[t_idx] <= req_ff.task_priority;
   end

   `ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe |-> $past(busy))
   `ASSERT_IMPL(a_idle_after_last, clock, reset, (rsp_strobe && rsp_word.last) |-> !busy)
   `ASSERT_IMPL(a_wake_clears, clock, reset,
      (rsp_strobe && rsp_word.woken_valid) |-> !wait_ff[TW'(rsp_word.woken_task)])
endmodule
